@@ rtl/bcec_pkg.sv @@
// Shared types and constants for the block-cyclic extent calculator.
// No dependencies; the top level and the testbench refer to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bcec_pkg;

    localparam int BSIZE_W   = 16;   // block size
    localparam int RANK_W    = 12;   // node rank
    localparam int GSIZE_W   = 13;   // group size
    localparam int STRIDE_W  = BSIZE_W + GSIZE_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [1:0] {
        DIR_ALL = 2'd0,
        DIR_COL = 2'd1,
        DIR_ROW = 2'd2,
        DIR_BAD = 2'd3
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_SIZE = 3'd0,
        REG_RANK_ALL   = 3'd1,
        REG_SIZE_ALL   = 3'd2,
        REG_RANK_COL   = 3'd3,
        REG_SIZE_COL   = 3'd4,
        REG_RANK_ROW   = 3'd5,
        REG_SIZE_ROW   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  direction;
        logic [29:0] align;
        logic [29:0] length;
    } in_t;

    typedef struct packed {
        logic [29:0]        local_len;
        logic [BSIZE_W-1:0] first_size;
        logic [RANK_W-1:0]  first_owner;
        logic [BSIZE_W-1:0] last_size;
        logic [RANK_W-1:0]  last_owner;
        logic               bad_direction;
    } out_t;

endpackage

`default_nettype wire

@@ rtl/bcec_pipe.sv @@
// Delay line with a shared advance enable; carries side data past the dividers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bcec_pipe #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] sr_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign q = sr_reg[N-1];

endmodule

`default_nettype wire

@@ rtl/bcec_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, DW stages.
// No dependencies. The divisor must be nonzero.
`timescale 1ns / 1ps
`default_nettype none

module bcec_div #(
    parameter int DW = 32,
    parameter int VW = 16
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [DW-1:0] num,
    input  wire logic [VW-1:0] den,
    output logic      [DW-1:0] quo,
    output logic      [VW-1:0] rem
);

    logic [VW-1:0] rem_reg  [DW];
    logic [DW-1:0] num_reg  [DW];
    logic [VW-1:0] den_reg  [DW-1];
    logic [VW-1:0] rem_next [DW];
    logic [DW-1:0] num_next [DW];

    always_comb
    begin
        logic [VW-1:0] rem_in;
        logic [DW-1:0] num_in;
        logic [VW-1:0] den_in;
        logic [VW:0]   trial;
        logic          ge;
        for (int k = 0; k < DW; k++)
        begin
            if (k == 0)
            begin
                rem_in = '0;
                num_in = num;
                den_in = den;
            end
            else
            begin
                rem_in = rem_reg[k-1];
                num_in = num_reg[k-1];
                den_in = den_reg[k-1];
            end
            trial       = {rem_in, num_in[DW-1]};
            ge          = (trial >= {1'b0, den_in});
            rem_next[k] = ge ? VW'(trial - {1'b0, den_in}) : trial[VW-1:0];
            num_next[k] = {num_in[DW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next[0];
            num_reg[0] <= num_next[0];
            den_reg[0] <= den;
            for (int k = 1; k < DW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                num_reg[k] <= num_next[k];
            end
            for (int k = 1; k < DW - 1; k++)
            begin
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign quo = num_reg[DW-1];
    assign rem = rem_reg[DW-1];

endmodule

`default_nettype wire

@@ rtl/block_cyclic_extent_calc.sv @@
// Block-cyclic extent calculator: for one query gives the element count owned
// by this node and the sizes and owners of the first and last blocks.
// One query per cycle; a query may enter every clock while the pipe advances.
// Input transactions: in_valid/in_ready with in_data; results: out_valid/
// out_ready with out_data, one result per query, in order.
// Configuration: cfg_we writes cfg_data into the register selected by
// cfg_index (0 block size, 1..6 rank/size of whole, column and row groups);
// indexes past the list are ignored. Write only while no query is in flight.
// Datapath: stage 0, then three chained phases of bit-per-stage dividers of
// width D1W = max(LENGTH_BITS+1, 12) (offset/stride, owner and middle block
// count, then modulo the group size), each followed by a register stage M1,
// M2 or M3, then M4 and the output register.
// Throughput: one transaction per cycle while the pipe advances. The whole pipe advances together
// whenever the two-entry output stage (output register plus skid) has room,
// so a stalled receiver holds results without loss; in_ready drops only once
// the skid entry fills.
// Reset clears all valid bits and loads the register defaults (block size 1,
// ranks 0, group sizes 1).
`timescale 1ns / 1ps
`default_nettype none

module block_cyclic_extent_calc #(
    parameter int LENGTH_BITS = 30
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire bcec_pkg::in_t                    in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output bcec_pkg::out_t                        out_data,
    input  wire logic                             cfg_we,
    input  wire logic [bcec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bcec_pkg::CFG_DAT_W-1:0]   cfg_data
);

    localparam int LB  = LENGTH_BITS;
    localparam int BW  = bcec_pkg::BSIZE_W;
    localparam int RW  = bcec_pkg::RANK_W;
    localparam int GW  = bcec_pkg::GSIZE_W;
    localparam int SW  = bcec_pkg::STRIDE_W;
    localparam int D1W = (LB + 1 > 12) ? LB + 1 : 12;
    localparam int CW  = (LB > SW) ? LB : SW;
    localparam int NV  = 3 * D1W + 5;

    localparam int P1W = 1 + RW + GW + BW + SW + LB;
    localparam int P2W = 1 + RW + GW + SW + BW + BW + GW + LB + 1;
    localparam int P3W = P2W + GW + GW + LB;

    // ---------------- configuration registers
    logic [BW-1:0] block_size_reg;
    logic [RW-1:0] rank_all_reg, rank_col_reg, rank_row_reg;
    logic [GW-1:0] size_all_reg, size_col_reg, size_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BW'(1);
            rank_all_reg   <= '0;
            size_all_reg   <= GW'(1);
            rank_col_reg   <= '0;
            size_col_reg   <= GW'(1);
            rank_row_reg   <= '0;
            size_row_reg   <= GW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bcec_pkg::REG_BLOCK_SIZE: block_size_reg <= cfg_data;
                bcec_pkg::REG_RANK_ALL:   rank_all_reg   <= cfg_data[RW-1:0];
                bcec_pkg::REG_SIZE_ALL:   size_all_reg   <= cfg_data[GW-1:0];
                bcec_pkg::REG_RANK_COL:   rank_col_reg   <= cfg_data[RW-1:0];
                bcec_pkg::REG_SIZE_COL:   size_col_reg   <= cfg_data[GW-1:0];
                bcec_pkg::REG_RANK_ROW:   rank_row_reg   <= cfg_data[RW-1:0];
                bcec_pkg::REG_SIZE_ROW:   size_row_reg   <= cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control
    logic          en;
    logic [NV-1:0] vld_reg;
    logic          out_vld_reg, skid_vld_reg;
    bcec_pkg::out_t out_data_reg, skid_data_reg, m4_reg;
    logic          push;

    assign en       = !skid_vld_reg;
    assign in_ready = en;
    assign push     = en && vld_reg[NV-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[NV-2:0], in_valid};
            end
            if (skid_vld_reg)
            begin
                if (out_ready || !out_vld_reg)
                begin
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (!out_vld_reg || out_ready)
                begin
                    out_vld_reg <= 1'b1;
                end
                else
                begin
                    skid_vld_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (out_ready || !out_vld_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (!out_vld_reg || out_ready)
            begin
                out_data_reg <= m4_reg;
            end
            else
            begin
                skid_data_reg <= m4_reg;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // ---------------- stage 0: select group, form stride
    logic          s0_bad_reg;
    logic [RW-1:0] s0_me_reg;
    logic [GW-1:0] s0_np_reg;
    logic [BW-1:0] s0_nb_reg;
    logic [SW-1:0] s0_stride_reg;
    logic [LB-1:0] s0_align_reg, s0_len_reg;
    logic [LB:0]   s0_asum_reg;

    logic [RW-1:0] me_next;
    logic [GW-1:0] np_next, sc_next;
    logic [BW-1:0] nb_next;
    logic [LB-1:0] align_next, len_next;

    always_comb
    begin
        nb_next    = (block_size_reg == '0) ? BW'(1) : block_size_reg;
        align_next = LB'(in_data.align);
        len_next   = LB'(in_data.length);
        sc_next    = GW'(1);
        case (in_data.direction)
            bcec_pkg::DIR_ALL:
            begin
                me_next = rank_all_reg;
                np_next = (size_all_reg == '0) ? GW'(1) : size_all_reg;
            end
            bcec_pkg::DIR_COL:
            begin
                me_next = rank_col_reg;
                np_next = (size_col_reg == '0) ? GW'(1) : size_col_reg;
            end
            default:
            begin
                me_next = rank_row_reg;
                np_next = (size_row_reg == '0) ? GW'(1) : size_row_reg;
            end
        endcase
        if (in_data.direction == bcec_pkg::DIR_ROW)
        begin
            sc_next = (size_col_reg == '0) ? GW'(1) : size_col_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_bad_reg    <= (in_data.direction == bcec_pkg::DIR_BAD);
            s0_me_reg     <= me_next;
            s0_np_reg     <= np_next;
            s0_nb_reg     <= nb_next;
            s0_stride_reg <= SW'(nb_next) * SW'(sc_next);
            s0_align_reg  <= align_next;
            s0_len_reg    <= len_next;
            s0_asum_reg   <= (LB+1)'(align_next) + (LB+1)'(len_next);
        end
    end

    // ---------------- phase 1 dividers
    logic [D1W-1:0] q1;
    logic [SW-1:0]  r1;
    logic [BW-1:0]  r2, r3;
    logic [GW-1:0]  rme;

    bcec_div #(.DW(D1W), .VW(SW)) u_div_first (
        .clk(clk), .en(en), .num(D1W'(s0_align_reg)), .den(s0_stride_reg),
        .quo(q1), .rem(r1)
    );
    bcec_div #(.DW(D1W), .VW(BW)) u_div_sfirst (
        .clk(clk), .en(en), .num(D1W'(s0_align_reg)), .den(s0_nb_reg),
        .quo(), .rem(r2)
    );
    bcec_div #(.DW(D1W), .VW(BW)) u_div_slast (
        .clk(clk), .en(en), .num(D1W'(s0_asum_reg)), .den(s0_nb_reg),
        .quo(), .rem(r3)
    );
    bcec_div #(.DW(D1W), .VW(GW)) u_div_me (
        .clk(clk), .en(en), .num(D1W'(s0_me_reg)), .den(s0_np_reg),
        .quo(), .rem(rme)
    );

    logic [P1W-1:0] p1_q;
    logic           p1_bad;
    logic [RW-1:0]  p1_me;
    logic [GW-1:0]  p1_np;
    logic [BW-1:0]  p1_nb;
    logic [SW-1:0]  p1_stride;
    logic [LB-1:0]  p1_len;

    bcec_pipe #(.W(P1W), .N(D1W)) u_pipe1 (
        .clk(clk), .en(en),
        .d({s0_bad_reg, s0_me_reg, s0_np_reg, s0_nb_reg, s0_stride_reg, s0_len_reg}),
        .q(p1_q)
    );
    assign {p1_bad, p1_me, p1_np, p1_nb, p1_stride, p1_len} = p1_q;

    // ---------------- M1: first block sizes, remaining length
    logic [BW-1:0] sfirst_next, slast_next;
    logic [LB-1:0] nfirst_next, rest_next;

    always_comb
    begin
        logic [BW-1:0] hd;
        logic [BW-1:0] tl;
        logic [SW-1:0] fd;
        hd = p1_nb - r2;
        tl = (r3 == '0) ? p1_nb : r3;
        fd = p1_stride - r1;
        sfirst_next = (CW'(hd) < CW'(p1_len)) ? hd : BW'(p1_len);
        slast_next  = (CW'(tl) < CW'(p1_len)) ? tl : BW'(p1_len);
        nfirst_next = (CW'(fd) < CW'(p1_len)) ? LB'(fd) : p1_len;
        rest_next   = p1_len - nfirst_next;
    end

    logic           m1_bad_reg, m1_rest0_reg;
    logic [RW-1:0]  m1_me_reg;
    logic [GW-1:0]  m1_np_reg, m1_mem_reg;
    logic [SW-1:0]  m1_stride_reg;
    logic [BW-1:0]  m1_sfirst_reg, m1_slast_reg;
    logic [LB-1:0]  m1_nfirst_reg, m1_rest_reg;
    logic [D1W-1:0] m1_q1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_bad_reg    <= p1_bad;
            m1_me_reg     <= p1_me;
            m1_np_reg     <= p1_np;
            m1_stride_reg <= p1_stride;
            m1_sfirst_reg <= sfirst_next;
            m1_slast_reg  <= slast_next;
            m1_mem_reg    <= rme;
            m1_nfirst_reg <= nfirst_next;
            m1_rest_reg   <= rest_next;
            m1_rest0_reg  <= (rest_next == '0);
            m1_q1_reg     <= q1;
        end
    end

    // ---------------- phase 2 dividers: first owner, middle blocks
    logic [GW-1:0]  r4;
    logic [D1W-1:0] q5;
    logic [SW-1:0]  r5;

    bcec_div #(.DW(D1W), .VW(GW)) u_div_owner (
        .clk(clk), .en(en), .num(m1_q1_reg), .den(m1_np_reg),
        .quo(), .rem(r4)
    );
    bcec_div #(.DW(D1W), .VW(SW)) u_div_rest (
        .clk(clk), .en(en), .num(D1W'(m1_rest_reg)), .den(m1_stride_reg),
        .quo(q5), .rem(r5)
    );

    logic [P2W-1:0] p2_q;
    logic           p2_bad, p2_rest0;
    logic [RW-1:0]  p2_me;
    logic [GW-1:0]  p2_np, p2_mem;
    logic [SW-1:0]  p2_stride;
    logic [BW-1:0]  p2_sfirst, p2_slast;
    logic [LB-1:0]  p2_nfirst;

    bcec_pipe #(.W(P2W), .N(D1W)) u_pipe2 (
        .clk(clk), .en(en),
        .d({m1_bad_reg, m1_me_reg, m1_np_reg, m1_stride_reg, m1_sfirst_reg,
            m1_slast_reg, m1_mem_reg, m1_nfirst_reg, m1_rest0_reg}),
        .q(p2_q)
    );
    assign {p2_bad, p2_me, p2_np, p2_stride, p2_sfirst, p2_slast, p2_mem,
            p2_nfirst, p2_rest0} = p2_q;

    // ---------------- M2: next owner, last block size, middle count
    logic [GW-1:0] inc_next;
    logic [GW-1:0] nxt_next;
    logic [LB-1:0] nlast_next, mid_next;

    always_comb
    begin
        inc_next   = r4 + GW'(1);
        nxt_next   = (inc_next == p2_np) ? '0 : inc_next;
        // an exact multiple leaves a full last block, so one fewer in the middle
        nlast_next = (r5 == '0) ? LB'(p2_stride) : LB'(r5);
        mid_next   = (r5 == '0) ? LB'(q5) - LB'(1) : LB'(q5);
    end

    logic           m2_bad_reg, m2_rest0_reg;
    logic [RW-1:0]  m2_me_reg;
    logic [GW-1:0]  m2_np_reg, m2_mem_reg, m2_ofirst_reg, m2_next_reg;
    logic [SW-1:0]  m2_stride_reg;
    logic [BW-1:0]  m2_sfirst_reg, m2_slast_reg;
    logic [LB-1:0]  m2_nfirst_reg, m2_nlast_reg, m2_mid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_bad_reg    <= p2_bad;
            m2_rest0_reg  <= p2_rest0;
            m2_me_reg     <= p2_me;
            m2_np_reg     <= p2_np;
            m2_mem_reg    <= p2_mem;
            m2_stride_reg <= p2_stride;
            m2_sfirst_reg <= p2_sfirst;
            m2_slast_reg  <= p2_slast;
            m2_nfirst_reg <= p2_nfirst;
            m2_ofirst_reg <= r4;
            m2_next_reg   <= nxt_next;
            m2_nlast_reg  <= nlast_next;
            m2_mid_reg    <= mid_next;
        end
    end

    // ---------------- phase 3 divider: full rounds and leftover blocks
    logic [D1W-1:0] midq;
    logic [GW-1:0]  midr;

    bcec_div #(.DW(D1W), .VW(GW)) u_div_mid (
        .clk(clk), .en(en), .num(D1W'(m2_mid_reg)), .den(m2_np_reg),
        .quo(midq), .rem(midr)
    );

    logic [P3W-1:0] p3_q;
    logic           p3_bad, p3_rest0;
    logic [RW-1:0]  p3_me;
    logic [GW-1:0]  p3_np, p3_mem, p3_ofirst, p3_next;
    logic [SW-1:0]  p3_stride;
    logic [BW-1:0]  p3_sfirst, p3_slast;
    logic [LB-1:0]  p3_nfirst, p3_nlast;

    bcec_pipe #(.W(P3W), .N(D1W)) u_pipe3 (
        .clk(clk), .en(en),
        .d({m2_bad_reg, m2_me_reg, m2_np_reg, m2_stride_reg, m2_sfirst_reg,
            m2_slast_reg, m2_mem_reg, m2_nfirst_reg, m2_rest0_reg,
            m2_ofirst_reg, m2_next_reg, m2_nlast_reg}),
        .q(p3_q)
    );
    assign {p3_bad, p3_me, p3_np, p3_stride, p3_sfirst, p3_slast, p3_mem,
            p3_nfirst, p3_rest0, p3_ofirst, p3_next, p3_nlast} = p3_q;

    // ---------------- M3: last owner, partial sums
    logic [GW-1:0] olast_next;
    logic [LB-1:0] first_add_next, prod_next, nlast_add_next, stride_add_next;

    always_comb
    begin
        logic [GW:0]   osum;
        logic [GW:0]   rsum;
        logic [GW-1:0] rel;
        logic [LB-1:0] stride_lb;
        osum      = (GW+1)'(p3_next) + (GW+1)'(midr);
        rsum      = (GW+1)'(p3_mem) + (GW+1)'(p3_np) - (GW+1)'(p3_next);
        rel       = (rsum >= (GW+1)'(p3_np)) ? GW'(rsum - (GW+1)'(p3_np)) : GW'(rsum);
        stride_lb = LB'(p3_stride);
        if (p3_rest0)
        begin
            olast_next = p3_ofirst;
        end
        else
        begin
            olast_next = (osum >= (GW+1)'(p3_np)) ? GW'(osum - (GW+1)'(p3_np))
                                                  : GW'(osum);
        end
        first_add_next  = (GW'(p3_me) == p3_ofirst) ? p3_nfirst : '0;
        prod_next       = p3_rest0 ? '0 : LB'(midq[LB-1:0] * stride_lb);
        nlast_add_next  = (!p3_rest0 && GW'(p3_me) == olast_next) ? p3_nlast : '0;
        stride_add_next = (!p3_rest0 && rel < midr) ? stride_lb : '0;
    end

    logic          m3_bad_reg;
    logic [BW-1:0] m3_sfirst_reg, m3_slast_reg;
    logic [GW-1:0] m3_ofirst_reg, m3_olast_reg;
    logic [LB-1:0] m3_first_add_reg, m3_prod_reg, m3_nlast_add_reg, m3_stride_add_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_bad_reg        <= p3_bad;
            m3_sfirst_reg     <= p3_sfirst;
            m3_slast_reg      <= p3_slast;
            m3_ofirst_reg     <= p3_ofirst;
            m3_olast_reg      <= olast_next;
            m3_first_add_reg  <= first_add_next;
            m3_prod_reg       <= prod_next;
            m3_nlast_add_reg  <= nlast_add_next;
            m3_stride_add_reg <= stride_add_next;
        end
    end

    // ---------------- M4: final sum and result formatting
    bcec_pkg::out_t m4_next;

    always_comb
    begin
        logic [LB-1:0] local_sum;
        local_sum = m3_first_add_reg + m3_prod_reg + m3_nlast_add_reg + m3_stride_add_reg;
        if (m3_bad_reg)
        begin
            m4_next               = '0;
            m4_next.bad_direction = 1'b1;
        end
        else
        begin
            m4_next.local_len     = 30'(local_sum);
            m4_next.first_size    = m3_sfirst_reg;
            m4_next.first_owner   = m3_ofirst_reg[RW-1:0];
            m4_next.last_size     = m3_slast_reg;
            m4_next.last_owner    = m3_olast_reg[RW-1:0];
            m4_next.bad_direction = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m4_reg <= m4_next;
        end
    end

endmodule

`default_nettype wire

@@ sim/tb_block_cyclic_extent_calc.sv @@
// Self-checking testbench for block_cyclic_extent_calc: a typed table of queries
// at reset settings, then random queries over several register settings.
// Depends on rtl/bcec_pkg.sv and rtl/block_cyclic_extent_calc.sv.
`timescale 1ns / 1ps

module tb_block_cyclic_extent_calc;

    localparam int LEN_W       = 30;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 600;
    localparam int N_PHASES    = 10;
    localparam int PER_PHASE   = 143;
    localparam longint unsigned LEN_MAX = (64'd1 << LEN_W) - 1;

    typedef struct {
        bcec_pkg::dir_t d;
        logic [29:0]    a;
        logic [29:0]    l;
        bit             typed;
        bcec_pkg::out_t want;
    } query_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    bcec_pkg::in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    bcec_pkg::out_t out_data;
    logic cfg_we = 1'b0;
    logic [bcec_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bcec_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    // tb copy of the register file, indexed by cfg_idx_t
    longint unsigned regs [7];
    bcec_pkg::out_t extent_q [$];
    bcec_pkg::out_t typed_q [$];
    bit   typed_use_q [$];
    int   n_errors = 0;
    int   n_in = 0;
    int   n_out = 0;
    int   n_bad_dir = 0;
    int   idle_cycles = 0;

    block_cyclic_extent_calc #(.LENGTH_BITS(LEN_W)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned one_if_zero(longint unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic longint unsigned umin(longint unsigned a, longint unsigned b);
        return (a < b) ? a : b;
    endfunction

    // Expected answer for one query under the current register settings
    function automatic bcec_pkg::out_t extent_of(bcec_pkg::in_t q);
        longint unsigned nb, np, me, stride, al, ln;
        longint unsigned sfirst, slast, nfirst, ofirst, olast, cnt, rest;
        longint unsigned nxt, rel, nlast, mid;
        bcec_pkg::out_t r;
        r = '0;
        if (q.direction == bcec_pkg::DIR_BAD)
        begin
            r.bad_direction = 1'b1;
            return r;
        end
        al = q.align;
        ln = q.length;
        nb = one_if_zero(regs[bcec_pkg::REG_BLOCK_SIZE]);
        case (q.direction)
            bcec_pkg::DIR_ALL:
            begin
                me = regs[bcec_pkg::REG_RANK_ALL];
                np = one_if_zero(regs[bcec_pkg::REG_SIZE_ALL]);
            end
            bcec_pkg::DIR_COL:
            begin
                me = regs[bcec_pkg::REG_RANK_COL];
                np = one_if_zero(regs[bcec_pkg::REG_SIZE_COL]);
            end
            default:
            begin
                me = regs[bcec_pkg::REG_RANK_ROW];
                np = one_if_zero(regs[bcec_pkg::REG_SIZE_ROW]);
            end
        endcase
        sfirst = umin(nb - (al % nb), ln);
        slast = (al + ln) % nb;
        slast = umin((slast == 0) ? nb : slast, ln);
        // row direction strides over whole process rows
        stride = (q.direction == bcec_pkg::DIR_ROW)
                 ? nb * one_if_zero(regs[bcec_pkg::REG_SIZE_COL]) : nb;
        nfirst = umin(stride - (al % stride), ln);
        ofirst = (al / stride) % np;
        rest = ln - nfirst;
        cnt = (me == ofirst) ? nfirst : 0;
        if (rest == 0)
            olast = ofirst;
        else
        begin
            nxt = (ofirst + 1) % np;
            rel = (me + np - nxt) % np;
            nlast = rest % stride;
            if (nlast == 0)
                nlast = umin(rest, stride);
            rest -= nlast;
            mid = rest / stride;
            cnt += (mid / np) * stride;
            mid %= np;
            olast = (nxt + mid) % np;
            if (me == olast)
                cnt += nlast;
            if (rel < mid)
                cnt += stride;
        end
        r.local_len   = cnt[29:0];
        r.first_size  = sfirst[15:0];
        r.first_owner = ofirst[11:0];
        r.last_size   = slast[15:0];
        r.last_owner  = olast[11:0];
        return r;
    endfunction

    // input and output monitor, prediction and scoreboard
    always @(posedge clk)
    begin
        bcec_pkg::out_t want;
        string diff;
        if (in_valid && in_ready)
        begin
            n_in++;
            if (in_data.direction == bcec_pkg::DIR_BAD)
                n_bad_dir++;
            if (typed_q.size() != 0 && typed_use_q.pop_front())
                extent_q.push_back(typed_q.pop_front());
            else
            begin
                if (typed_q.size() != 0)
                    void'(typed_q.pop_front());
                extent_q.push_back(extent_of(in_data));
            end
        end
        if (out_valid && out_ready)
        begin
            n_out++;
            if (extent_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: result with nothing expected: %p", out_data);
            end
            else
            begin
                want = extent_q.pop_front();
                diff = "";
                if (out_data.local_len !== want.local_len)
                    diff = {diff, " local_len"};
                if (out_data.first_size !== want.first_size)
                    diff = {diff, " first_size"};
                if (out_data.first_owner !== want.first_owner)
                    diff = {diff, " first_owner"};
                if (out_data.last_size !== want.last_size)
                    diff = {diff, " last_size"};
                if (out_data.last_owner !== want.last_owner)
                    diff = {diff, " last_owner"};
                if (out_data.bad_direction !== want.bad_direction)
                    diff = {diff, " bad_direction"};
                if (diff != "")
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: result %0d mismatch in%s\n  exp %p\n  got %p",
                                 n_out, diff, want, out_data);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d idle cycles, %0d results pending",
                     idle_cycles, extent_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, stretches without stalls, one long hold-off
    initial
    begin
        int gap;
        int taken;
        bit no_stall;
        taken = 0;
        no_stall = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken % 64 == 0)
                no_stall = ($urandom_range(0, 3) == 0);
            if (taken == 300)
            begin
                // long hold-off so the pipe fills and in_ready drops
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = no_stall ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            taken++;
        end
    end

    bit tx_no_gap = 1'b0;

    task automatic send_query(bcec_pkg::in_t q);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= q;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (extent_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(bcec_pkg::cfg_idx_t idx, logic [15:0] val);
        logic [15:0] mask;
        mask = (idx == bcec_pkg::REG_BLOCK_SIZE) ? 16'hFFFF :
               (idx == bcec_pkg::REG_RANK_ALL || idx == bcec_pkg::REG_RANK_COL ||
                idx == bcec_pkg::REG_RANK_ROW) ? 16'h0FFF : 16'h1FFF;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        regs[idx] = val & mask;
    endtask

    task automatic setup_phase(int p);
        int sa, sc, sr;
        case (p)
            0:
            begin
                write_reg(bcec_pkg::REG_BLOCK_SIZE, 16'hFFFF);
                write_reg(bcec_pkg::REG_RANK_ALL, 16'd4095);
                write_reg(bcec_pkg::REG_SIZE_ALL, 16'd4096);
                write_reg(bcec_pkg::REG_RANK_COL, 16'd4095);
                write_reg(bcec_pkg::REG_SIZE_COL, 16'd4096);
                write_reg(bcec_pkg::REG_RANK_ROW, 16'd0);
                write_reg(bcec_pkg::REG_SIZE_ROW, 16'd4096);
            end
            1:
            begin
                // zero block and group sizes read as one
                write_reg(bcec_pkg::REG_BLOCK_SIZE, 16'd0);
                write_reg(bcec_pkg::REG_RANK_ALL, 16'd0);
                write_reg(bcec_pkg::REG_SIZE_ALL, 16'd0);
                write_reg(bcec_pkg::REG_RANK_COL, 16'd0);
                write_reg(bcec_pkg::REG_SIZE_COL, 16'd0);
                write_reg(bcec_pkg::REG_RANK_ROW, 16'd0);
                write_reg(bcec_pkg::REG_SIZE_ROW, 16'd0);
            end
            2:
            begin
                // oversize groups, ranks at or past the group size, data bits above width
                write_reg(bcec_pkg::REG_BLOCK_SIZE, 16'd3);
                write_reg(bcec_pkg::REG_RANK_ALL, 16'hF007);
                write_reg(bcec_pkg::REG_SIZE_ALL, 16'hFFFF);
                write_reg(bcec_pkg::REG_RANK_COL, 16'd3);
                write_reg(bcec_pkg::REG_SIZE_COL, 16'd3);
                write_reg(bcec_pkg::REG_RANK_ROW, 16'd9);
                write_reg(bcec_pkg::REG_SIZE_ROW, 16'd4);
            end
            default:
            begin
                sa = $urandom_range(1, 9);
                sc = $urandom_range(1, 6);
                sr = $urandom_range(1, 6);
                write_reg(bcec_pkg::REG_BLOCK_SIZE,
                          (p == 9) ? 16'($urandom_range(1, 65535))
                                   : 16'($urandom_range(1, 12)));
                write_reg(bcec_pkg::REG_RANK_ALL, 16'($urandom_range(0, sa)));
                write_reg(bcec_pkg::REG_SIZE_ALL, 16'(sa));
                write_reg(bcec_pkg::REG_RANK_COL, 16'($urandom_range(0, sc)));
                write_reg(bcec_pkg::REG_SIZE_COL, 16'(sc));
                write_reg(bcec_pkg::REG_RANK_ROW, 16'($urandom_range(0, sr)));
                write_reg(bcec_pkg::REG_SIZE_ROW, 16'(sr));
            end
        endcase
    endtask

    function automatic bcec_pkg::in_t random_query();
        bcec_pkg::in_t q;
        longint unsigned lim;
        int pick;
        pick = $urandom_range(0, 9);
        q.direction = ($urandom_range(0, 11) == 0) ? bcec_pkg::DIR_BAD
                                                   : 2'($urandom_range(0, 2));
        // most queries span a few dozen blocks so owners and middle counts vary
        lim = umin(one_if_zero(regs[bcec_pkg::REG_BLOCK_SIZE]) *
                   one_if_zero(regs[bcec_pkg::REG_SIZE_COL]) * 48, LEN_MAX);
        q.align  = (pick < 2) ? 30'($urandom) : 30'($urandom_range(0, 32'(lim)));
        q.length = (pick < 2) ? 30'($urandom) :
                   (pick == 2) ? 30'($urandom_range(0, 3)) : 30'($urandom_range(0, 32'(lim)));
        return q;
    endfunction

    // queries at reset settings: block size one, one node per group, so everything is local
    query_row_t reset_rows [] = '{
        '{bcec_pkg::DIR_ALL, 30'd0, 30'd0, 1'b1,
          '{30'd0, 16'd0, 12'd0, 16'd0, 12'd0, 1'b0}},
        '{bcec_pkg::DIR_ALL, 30'h3FFFFFFF, 30'h3FFFFFFF, 1'b1,
          '{30'h3FFFFFFF, 16'd1, 12'd0, 16'd1, 12'd0, 1'b0}},
        '{bcec_pkg::DIR_COL, 30'd5, 30'd1, 1'b1,
          '{30'd1, 16'd1, 12'd0, 16'd1, 12'd0, 1'b0}},
        '{bcec_pkg::DIR_ROW, 30'd0, 30'd7, 1'b1,
          '{30'd7, 16'd1, 12'd0, 16'd1, 12'd0, 1'b0}},
        '{bcec_pkg::DIR_ROW, 30'h3FFFFFFF, 30'd0, 1'b1,
          '{30'd0, 16'd0, 12'd0, 16'd0, 12'd0, 1'b0}},
        '{bcec_pkg::DIR_BAD, 30'h3FFFFFFF, 30'h3FFFFFFF, 1'b1,
          '{30'd0, 16'd0, 12'd0, 16'd0, 12'd0, 1'b1}},
        '{bcec_pkg::DIR_BAD, 30'd0, 30'd0, 1'b1,
          '{30'd0, 16'd0, 12'd0, 16'd0, 12'd0, 1'b1}},
        '{bcec_pkg::DIR_ALL, 30'h2AAAAAAA, 30'h15555555, 1'b1,
          '{30'h15555555, 16'd1, 12'd0, 16'd1, 12'd0, 1'b0}},
        '{bcec_pkg::DIR_COL, 30'h15555555, 30'h2AAAAAAA, 1'b1,
          '{30'h2AAAAAAA, 16'd1, 12'd0, 16'd1, 12'd0, 1'b0}},
        '{bcec_pkg::DIR_COL, 30'h3FFFFFFF, 30'd1, 1'b0, '0},
        '{bcec_pkg::DIR_ROW, 30'd1, 30'h3FFFFFFE, 1'b0, '0},
        '{bcec_pkg::DIR_ALL, 30'd12345, 30'd99, 1'b0, '0}
    };

    initial
    begin
        bcec_pkg::in_t q;
        for (int i = 0; i < 7; i++)
            regs[i] = (i == bcec_pkg::REG_BLOCK_SIZE || i == bcec_pkg::REG_SIZE_ALL ||
                       i == bcec_pkg::REG_SIZE_COL || i == bcec_pkg::REG_SIZE_ROW) ? 1 : 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (reset_rows[i])
        begin
            q.direction = reset_rows[i].d;
            q.align     = reset_rows[i].a;
            q.length    = reset_rows[i].l;
            typed_q.push_back(reset_rows[i].want);
            typed_use_q.push_back(reset_rows[i].typed);
            send_query(q);
        end
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            setup_phase(p);
            for (int k = 0; k < PER_PHASE; k++)
            begin
                if (k % 48 == 0)
                    tx_no_gap = ($urandom_range(0, 3) == 0);
                send_query(random_query());
            end
            tx_no_gap = 1'b0;
            drain();
        end

        repeat (120) @(posedge clk);
        $display("Covered %0d queries (%0d illegal direction) over %0d register settings,",
                 n_in, n_bad_dir, N_PHASES + 1);
        $display("with random stalls on both sides and one long result hold-off.");
        if (n_errors == 0 && extent_q.size() == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatches, %0d results missing", n_errors, extent_q.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/bcec_pkg.sv
rtl/bcec_pipe.sv
rtl/bcec_div.sv
rtl/block_cyclic_extent_calc.sv
sim/tb_block_cyclic_extent_calc.sv
